// ===== hdl/ffha_pkg.sv =====
// Package for the first-fit heap allocator: pool sizing, header layout,
// result type. No dependencies.
package ffha_pkg;

    localparam int POOL_BYTES   = 8192;
    localparam int HEADER_BYTES = 17;
    localparam int MIN_CAPACITY = 24;

    // Fixed widths of the request and result fields.
    localparam int ADDR_W = 13;
    localparam int REQ_W  = 14;

    // Header index, stored capacity and working sum widths.
    localparam int IDX_W  = $clog2(POOL_BYTES);
    localparam int CAP_W  = IDX_W + 1;
    localparam int SUM_W  = (IDX_W + 2 > REQ_W + 1) ? IDX_W + 2 : REQ_W + 1;
    localparam int HDR_W  = CAP_W + 1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic             free;
        logic [CAP_W-1:0] cap;
    } t_hdr;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic              ok;
    } t_res;

endpackage

// ===== hdl/ffha_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/ffha_walk.sv =====
// Chain walker: sequences header reads, merges, splits and write-backs.
// Depends on ffha_pkg and ffha_ram.
module ffha_walk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic                        i_op,
    input  logic [ffha_pkg::REQ_W-1:0]  i_req_bytes,
    input  logic [ffha_pkg::ADDR_W-1:0] i_release_addr,
    input  logic                        i_take,
    output logic                        o_idle,
    output ffha_pkg::t_res              o_res
);

    localparam int IW = ffha_pkg::IDX_W;
    localparam int SW = ffha_pkg::SUM_W;
    localparam int CW = ffha_pkg::CAP_W;
    localparam logic [SW-1:0] POOL = SW'(ffha_pkg::POOL_BYTES);
    localparam logic [SW-1:0] HDR  = SW'(ffha_pkg::HEADER_BYTES);
    localparam logic [SW-1:0] MINC = SW'(ffha_pkg::MIN_CAPACITY);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_A_CUR, S_A_NXT, S_A_FIT, S_A_SPLIT,
        S_F_CUR, S_F_NXT, S_DONE
    } t_state;

    t_state         r_state, n_state;
    logic [IW-1:0]  r_off, n_off;
    logic [CW-1:0]  r_cap, n_cap;
    logic [SW-1:0]  r_q, n_q;
    logic           r_dirty, n_dirty;
    logic [ffha_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic           r_ok, n_ok;

    logic           wr_en, rd_en;
    logic [IW-1:0]  wr_addr, rd_addr;
    ffha_pkg::t_hdr wr_hdr, rd_hdr;
    logic [ffha_pkg::HDR_W-1:0] rd_data;

    logic [SW-1:0]  cur_end;   // end of block at r_off using stored capacity r_cap
    logic [SW-1:0]  rd_end;    // end of block at r_off using capacity just read
    logic [SW-1:0]  nxt_end;   // end of successor whose header was just read
    logic [SW-1:0]  merged;    // capacity after absorbing that successor
    logic [SW-1:0]  mrg_end;
    logic [SW-1:0]  req_q;
    logic [SW-1:0]  rel;

    ffha_ram #(
        .WIDTH (ffha_pkg::HDR_W),
        .DEPTH (ffha_pkg::POOL_BYTES)
    ) u_hdr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_hdr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_hdr  = ffha_pkg::t_hdr'(rd_data);
    assign cur_end = SW'(r_off) + HDR + SW'(r_cap);
    assign rd_end  = SW'(r_off) + HDR + SW'(rd_hdr.cap);
    assign nxt_end = cur_end + HDR + SW'(rd_hdr.cap);
    assign merged  = SW'(r_cap) + HDR + SW'(rd_hdr.cap);
    assign mrg_end = SW'(r_off) + HDR + merged;
    assign req_q   = (SW'(i_req_bytes) > MINC) ? SW'(i_req_bytes) : MINC;
    assign rel     = SW'(i_release_addr);

    always_comb begin
        n_state = r_state;
        n_off   = r_off;
        n_cap   = r_cap;
        n_q     = r_q;
        n_dirty = r_dirty;
        n_addr  = r_addr;
        n_ok    = r_ok;
        wr_en   = 1'b0;
        wr_addr = r_off;
        wr_hdr  = '{free: 1'b1, cap: r_cap};
        rd_en   = 1'b0;
        rd_addr = r_off;
        case (r_state)
            S_INIT: begin
                // lay down the whole pool as one free block
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_hdr  = '{free: 1'b1, cap: CW'(POOL - HDR)};
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_accept) begin
                    n_addr = '0;
                    n_ok   = 1'b1;
                    if (i_op == ffha_pkg::OP_ALLOC) begin
                        n_q     = req_q;
                        n_off   = '0;
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_state = S_A_CUR;
                    end else if (rel < HDR) begin
                        n_state = S_DONE;
                    end else begin
                        n_off   = IW'(rel - HDR);
                        rd_en   = 1'b1;
                        rd_addr = IW'(rel - HDR);
                        n_state = S_F_CUR;
                    end
                end
            end
            S_A_CUR: begin
                n_cap   = rd_hdr.cap;
                n_dirty = 1'b0;
                if (rd_end > POOL) begin
                    n_ok    = 1'b0;
                    n_state = S_DONE;
                end else if (rd_hdr.free) begin
                    if (rd_end < POOL) begin
                        rd_en   = 1'b1;
                        rd_addr = IW'(rd_end);
                        n_state = S_A_NXT;
                    end else begin
                        n_state = S_A_FIT;
                    end
                end else if (rd_end < POOL) begin
                    rd_en   = 1'b1;
                    rd_addr = IW'(rd_end);
                    n_off   = IW'(rd_end);
                end else begin
                    n_ok    = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_A_NXT: begin
                // absorb free successors one by one
                if (rd_hdr.free && nxt_end <= POOL) begin
                    n_cap   = CW'(merged);
                    n_dirty = 1'b1;
                    if (mrg_end < POOL) begin
                        rd_en   = 1'b1;
                        rd_addr = IW'(mrg_end);
                    end else begin
                        n_state = S_A_FIT;
                    end
                end else begin
                    n_state = S_A_FIT;
                end
            end
            S_A_FIT: begin
                if (SW'(r_cap) >= r_q) begin
                    wr_en  = 1'b1;
                    n_addr = ffha_pkg::ADDR_W'(SW'(r_off) + HDR);
                    if (SW'(r_cap) >= r_q + HDR + MINC) begin
                        wr_hdr  = '{free: 1'b0, cap: CW'(r_q)};
                        n_state = S_A_SPLIT;
                    end else begin
                        wr_hdr  = '{free: 1'b0, cap: r_cap};
                        n_state = S_DONE;
                    end
                end else begin
                    // keep any merge, advance past the block
                    wr_en = r_dirty;
                    if (cur_end < POOL) begin
                        rd_en   = 1'b1;
                        rd_addr = IW'(cur_end);
                        n_off   = IW'(cur_end);
                        n_state = S_A_CUR;
                    end else begin
                        n_ok    = 1'b0;
                        n_state = S_DONE;
                    end
                end
            end
            S_A_SPLIT: begin
                wr_en   = 1'b1;
                wr_addr = IW'(SW'(r_off) + HDR + r_q);
                wr_hdr  = '{free: 1'b1, cap: CW'(SW'(r_cap) - HDR - r_q)};
                n_state = S_DONE;
            end
            S_F_CUR: begin
                wr_en   = 1'b1;
                wr_hdr  = '{free: 1'b1, cap: rd_hdr.cap};
                n_cap   = rd_hdr.cap;
                if (rd_end < POOL) begin
                    rd_en   = 1'b1;
                    rd_addr = IW'(rd_end);
                    n_state = S_F_NXT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_F_NXT: begin
                if (rd_hdr.free && nxt_end <= POOL) begin
                    wr_en  = 1'b1;
                    wr_hdr = '{free: 1'b1, cap: CW'(merged)};
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_off   <= '0;
            r_cap   <= '0;
            r_q     <= '0;
            r_dirty <= 1'b0;
            r_addr  <= '0;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_off   <= n_off;
            r_cap   <= n_cap;
            r_q     <= n_q;
            r_dirty <= n_dirty;
            r_addr  <= n_addr;
            r_ok    <= n_ok;
        end
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_res  = '{valid: (r_state == S_DONE), addr: r_addr, ok: r_ok};

`ifndef NO_ASSERTIONS
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("header read and write hit the same entry");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && r_state == S_IDLE) |=> (r_state != S_IDLE))
        else $error("accepted request did not start");
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_ok) |-> (r_addr == '0))
        else $error("failed allocation carries an address");
`endif

endmodule

// ===== hdl/first_fit_heap_allocator_top.sv =====
// First-fit heap allocator top level: request handshake and result register.
// Depends on ffha_pkg and ffha_walk.
//
// The block keeps a pool of POOL_BYTES bytes as a chain of blocks, each a
// header (capacity and free flag) of HEADER_BYTES followed by its contents;
// all headers live in one single-port-read, single-port-write RAM with one
// header per pool offset. After reset the block lays down a single free
// block over the whole pool before it takes a request. An allocate request
// walks the chain from offset 0 with one header read per cycle: it passes
// each used block, absorbs each free neighbour while coalescing, checks the
// fit and, when the block is large enough, splits it, so latency grows with
// fragmentation. A free request reads the header, marks it free, and absorbs
// the next block when that is free too; a free whose address lies below
// HEADER_BYTES does nothing. One request is in flight at a time; a finished
// result sits in an output register so the next request can be taken while
// the consumer still stalls.
module first_fit_heap_allocator_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_op,
    input  logic [ffha_pkg::REQ_W-1:0]  i_req_bytes,
    input  logic [ffha_pkg::ADDR_W-1:0] i_release_addr,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ffha_pkg::ADDR_W-1:0] o_granted_addr,
    output logic                        o_ok
);

    logic                        idle;
    logic                        accept;
    logic                        take;
    ffha_pkg::t_res              res;
    logic                        r_out_valid;
    logic [ffha_pkg::ADDR_W-1:0] r_granted_addr;
    logic                        r_ok;

    // hold requests off whenever the walker is busy
    assign o_in_stall = !idle;
    assign accept     = i_in_valid && idle;
    // move the result across once the output register is free or draining
    assign take       = res.valid && (!r_out_valid || !i_out_stall);

    ffha_walk u_walk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_op           (i_op),
        .i_req_bytes    (i_req_bytes),
        .i_release_addr (i_release_addr),
        .i_take         (take),
        .o_idle         (idle),
        .o_res          (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid    <= 1'b0;
            r_granted_addr <= '0;
            r_ok           <= 1'b0;
        end else begin
            if (take) begin
                r_out_valid    <= 1'b1;
                r_granted_addr <= res.addr;
                r_ok           <= res.ok;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_granted_addr = r_granted_addr;
    assign o_ok           = r_ok;

endmodule
